/* sv/move_to_front_list_top_macros.svh */
// ----------------------------------------------------------------------------
// move_to_front_list_top_macros.svh
// assertion helpers for the move-to-front list checker
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_TOP_MACROS_SVH
`define MOVE_TO_FRONT_LIST_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mtf_pkg.sv */
// ----------------------------------------------------------------------------
// mtf_pkg
// types and codes shared by the move-to-front list modules
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    localparam int DATA_W   = 32;  // input tdata width
    localparam int POS_W    = 8;
    localparam int CNT_W    = 9;
    localparam int OUT_DW   = 24;  // position + entry_count padded to bytes

    typedef enum logic [0:0] {
        ACT_APPEND = 1'b0,
        ACT_FIND   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STS_FOUND  = 2'd0,
        STS_MISS   = 2'd1,
        STS_APPEND = 2'd2,
        STS_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FRONT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_res;

endpackage

`default_nettype wire

/* sv/move_to_front_list_top.sv */
// ----------------------------------------------------------------------------
// move_to_front_list_top
// move-to-front self-organizing list with stream ports
// ----------------------------------------------------------------------------
// Input channel (s side): one word per request. tuser is the action (0 append,
// 1 find), tdata the value. Output channel (m side): one word per request,
// tuser the status, tdata the hit position and the entry count.
// An append's result sits in the output register on the cycle after the
// request is taken. A find reads the list one entry at a time through a
// single comparator, a read state and a compare state per entry examined;
// on a hit at position p the entries ahead shift back one place each,
// through a read state and a write state, then the value is written to
// the front. Only one request is in flight; s_tready is high only while
// the sequencer is idle and the output register is empty or being drained.
// If the receiver stalls, the result holds in the output register and no new
// request is taken until it leaves. Reset empties the list and drops any
// pending result; list contents are not cleared, since an entry is only
// read after it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_list_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [mtf_pkg::DATA_W-1:0]  i_s_tdata,  // [31:0] value
    input  wire logic                        i_s_tuser,  // [0] action
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [mtf_pkg::OUT_DW-1:0]  o_m_tdata,  // [7:0] position,
                                                         // [16:8] entry_count
    output logic      [1:0]                  o_m_tuser   // [1:0] status
);
    import mtf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl               w_mem;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0] w_rdata;
    t_res                   w_res;
    logic [AW-1:0]          w_pos;
    logic [CW-1:0]          w_count;
    logic                   w_out_free;

    logic                   r_out_valid;
    t_status                r_status;
    logic [POS_W-1:0]       r_pos;
    logic [CNT_W-1:0]       r_count;

    assign w_out_free = !r_out_valid || i_m_tready;

    mtf_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_value    (VALUE_WIDTH'(i_s_tdata)),
        .i_out_free (w_out_free),
        .o_ready    (o_s_tready),
        .o_mem      (w_mem),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_res      (w_res),
        .o_pos      (w_pos),
        .o_count    (w_count)
    );

    mtf_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register: result waits here while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res.valid) begin
            r_status <= w_res.status;
            r_pos    <= POS_W'(w_pos);
            r_count  <= CNT_W'(w_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_count, r_pos});
    assign o_m_tuser  = r_status;

endmodule

`default_nettype wire

/* sv/mtf_store.sv */
// ----------------------------------------------------------------------------
// mtf_store
// list storage: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire mtf_pkg::t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [VALUE_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [VALUE_WIDTH-1:0] o_rdata
);
    import mtf_pkg::*;

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/mtf_ctrl.sv */
// ----------------------------------------------------------------------------
// mtf_ctrl
// sequencer: scans the list through one comparator, then shifts entries
// back one place a step and puts the hit at the front
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_ctrl #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(DEPTH),
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic                   i_action,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_out_free,
    output logic                        o_ready,
    output mtf_pkg::t_mem_ctl           o_mem,
    output logic      [AW-1:0]          o_waddr,
    output logic      [VALUE_WIDTH-1:0] o_wdata,
    output logic      [AW-1:0]          o_raddr,
    input  wire logic [VALUE_WIDTH-1:0] i_rdata,
    output mtf_pkg::t_res               o_res,
    output logic      [AW-1:0]          o_pos,
    output logic      [CW-1:0]          o_count
);
    import mtf_pkg::*;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_idx,   n_idx;
    logic [AW-1:0]          r_pos,   n_pos;
    logic [CW-1:0]          r_count, n_count;
    logic [VALUE_WIDTH-1:0] r_val,   n_val;
    logic                   w_hit;
    logic                   w_last;

    // the one shared comparator
    assign w_hit  = (i_rdata == r_val);
    assign w_last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_val <= n_val;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_count    = r_count;
        n_val      = r_val;
        o_ready    = 1'b0;
        o_mem      = '0;
        o_waddr    = r_idx;
        o_wdata    = r_val;
        o_raddr    = r_idx;
        o_res      = '{valid: 1'b0, status: STS_MISS};
        o_pos      = '0;
        o_count    = r_count;

        unique case (r_state)
            S_IDLE: begin
                o_ready = i_out_free;
                if (i_valid && i_out_free) begin
                    n_val = i_value;
                    if (i_action == ACT_APPEND) begin
                        if (r_count == CW'(DEPTH)) begin
                            o_res = '{valid: 1'b1, status: STS_FULL};
                        end else begin
                            o_mem.we = 1'b1;
                            o_waddr  = r_count[AW-1:0];
                            o_wdata  = i_value;
                            n_count  = r_count + CW'(1);
                            o_count  = r_count + CW'(1);
                            o_res    = '{valid: 1'b1, status: STS_APPEND};
                        end
                    end else if (r_count == '0) begin
                        o_res = '{valid: 1'b1, status: STS_MISS};
                    end else begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_mem.re = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (w_hit) begin
                    n_pos = r_idx;
                    if (r_idx == '0) begin
                        o_res   = '{valid: 1'b1, status: STS_FOUND};
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end else if (w_last) begin
                    o_res   = '{valid: 1'b1, status: STS_MISS};
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_SH_RD: begin
                o_mem.re = 1'b1;
                o_raddr  = r_idx - AW'(1);
                n_state  = S_SH_WR;
            end
            S_SH_WR: begin
                o_mem.we = 1'b1;
                o_waddr  = r_idx;
                o_wdata  = i_rdata;
                n_idx    = r_idx - AW'(1);
                n_state  = (r_idx == AW'(1)) ? S_FRONT : S_SH_RD;
            end
            S_FRONT: begin
                o_mem.we = 1'b1;
                o_waddr  = '0;
                o_wdata  = r_val;
                o_pos    = r_pos;
                o_res    = '{valid: 1'b1, status: STS_FOUND};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/mtf_checker.sv */
// ----------------------------------------------------------------------------
// mtf_checker
// port-level checks for the move-to-front list, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "move_to_front_list_top_macros.svh"

module mtf_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_tvalid,
    input wire logic                        i_s_tready,
    input wire logic                        i_s_tuser,
    input wire logic                        i_m_tvalid,
    input wire logic                        i_m_tready,
    input wire logic [mtf_pkg::OUT_DW-1:0]  i_m_tdata,
    input wire logic [1:0]                  i_m_tuser
);
    import mtf_pkg::*;

    `MTF_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result word changed")
    `MTF_ASSERT_NOW(a_one_in_flight, i_s_tready && i_m_tvalid, i_m_tready, "request taken while a result is stuck")
    `MTF_ASSERT_NEXT(a_append_fast, i_s_tvalid && i_s_tready && (i_s_tuser == ACT_APPEND), i_m_tvalid, "append result late")
    `MTF_ASSERT_NOW(a_full_count, i_m_tvalid && (i_m_tuser == STS_FULL), i_m_tdata[16:8] == CNT_W'(DEPTH), "full drop with short count")
    `MTF_ASSERT_NOW(a_pos_zero, i_m_tvalid && (i_m_tuser != STS_FOUND), i_m_tdata[7:0] == '0, "position set without a hit")

endmodule

bind move_to_front_list_top mtf_checker #(
    .DEPTH (DEPTH)
) u_mtf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/sv/tb_move_to_front_list_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_list_top
// self-checking bench for the move-to-front list block
// ----------------------------------------------------------------------------
// Append and find words go in on the s side, one status word per request comes
// back on the m side. A scoreboard keeps its own copy of the list, predicts
// every status word as a request is taken and checks responses in order.
// A short directed run covers the corner cases. A long random run, mostly hits
// on values known to be in the list, follows under three idle patterns. It
// includes one long output hold-off to back up the input.
// ----------------------------------------------------------------------------

module tb_move_to_front_list_top;

    import mtf_pkg::*;

    localparam int LIST_DEPTH      = 16;
    localparam int VAL_W           = 32;
    localparam int RANDOM_ITEMS    = 1950;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } t_lookup_result;

    class mtf_list_scoreboard;
        logic [VAL_W-1:0] list_vals [LIST_DEPTH];
        int unsigned      list_count;
        t_lookup_result   expected_results [$];
        int unsigned      mismatches;

        function new();
            list_count = 0;
            mismatches = 0;
        endfunction

        // advance the shadow list and queue the status word it implies
        function void note_request(t_action act, logic [VAL_W-1:0] value);
            t_lookup_result res;
            int             hit;
            int             i;
            hit          = -1;
            res.position = '0;
            if (act == ACT_APPEND) begin
                if (list_count >= LIST_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    list_vals[list_count] = value;
                    list_count++;
                    res.status = STS_APPEND;
                end
            end else begin
                for (i = 0; i < list_count; i++) begin
                    if (hit < 0 && list_vals[i] == value)
                        hit = i;
                end
                if (hit >= 0) begin
                    // entries ahead of the hit slide back one place
                    for (i = hit; i > 0; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[0] = value;
                    res.status   = STS_FOUND;
                    res.position = POS_W'(hit);
                end else begin
                    res.status = STS_MISS;
                end
            end
            res.entry_count = CNT_W'(list_count);
            expected_results.insert(expected_results.size(), res);
        endfunction

        function void check_response(t_status st, logic [POS_W-1:0] pos,
                                     logic [CNT_W-1:0] cnt);
            t_lookup_result exp_res;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d position %0d count %0d",
                             st, pos, cnt);
                return;
            end
            exp_res = expected_results[0];
            expected_results.delete(0);
            if (st !== exp_res.status || pos !== exp_res.position
                    || cnt !== exp_res.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d position %0d count %0d, %s %0d %0d %0d",
                             exp_res.status, exp_res.position, exp_res.entry_count,
                             "got", st, pos, cnt);
            end
        endfunction
    endclass

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;   // [31:0] value
    logic                s_tuser  = 1'b0; // [0] action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;         // [7:0] position, [16:8] entry_count
    logic [1:0]          m_tuser;         // [1:0] status

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    bit          hold_off_req = 1'b0;

    mtf_list_scoreboard sb = new();

    move_to_front_list_top #(
        .DEPTH       (LIST_DEPTH),
        .VALUE_WIDTH (VAL_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // output side ready pattern, with one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_response(t_status'(m_tuser), m_tdata[POS_W-1:0],
                              m_tdata[8 +: CNT_W]);
    end

    // offer one word, possibly after a few idle cycles, and wait for the take
    task automatic send_word(t_action act, logic [VAL_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(act, value);
    endtask

    initial begin
        int          roll;
        int unsigned drain_cycles;

        snd_idle_pct = 7;
        rcv_idle_pct = 51;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner cases: empty list, front hit, duplicates, full list, deepest hit
        send_word(ACT_FIND,   32'h0000_0000);
        send_word(ACT_APPEND, 32'h0000_0000);
        send_word(ACT_FIND,   32'h0000_0000);
        send_word(ACT_APPEND, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, 32'h0000_0000);
        send_word(ACT_APPEND, 32'h8000_0001);
        send_word(ACT_FIND,   32'h8000_0001);
        send_word(ACT_FIND,   32'h0000_0000);
        send_word(ACT_FIND,   32'h7FFF_FFFE);
        while (sb.list_count < LIST_DEPTH)
            send_word(ACT_APPEND, $urandom);
        send_word(ACT_APPEND, 32'h5555_AAAA);
        send_word(ACT_FIND,   sb.list_vals[LIST_DEPTH-1]);
        send_word(ACT_FIND,   32'hFFFF_FFFF);
        send_word(ACT_FIND,   32'h1234_5678);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                snd_idle_pct = 51;
                rcv_idle_pct = 7;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                hold_off_req = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 60)
                send_word(ACT_FIND, sb.list_vals[$urandom_range(sb.list_count - 1)]);
            else if (roll < 75)
                send_word(ACT_FIND, sb.list_vals[sb.list_count - 1]);
            else if (roll < 88)
                send_word(ACT_FIND, $urandom);
            else
                send_word(ACT_APPEND, $urandom);
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (sb.expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
